// File: rtl/core/dep_pkg.sv
// shared types, constants and index helpers for the excitation phase unit
`default_nettype none

package dep_pkg;

    localparam int ORB_MAX          = 64;
    localparam int DEF_NUM_ORBITALS = 64;
    localparam int IDX_W            = 6;
    localparam int CNT_W            = 7;
    localparam int S_TDATA_W        = 2 * ORB_MAX;
    localparam int OUT_FIELD_W      = 4 * IDX_W + 2;
    localparam int M_TDATA_W        = 32;

    typedef enum logic {
        CMD_SINGLE = 1'b0,
        CMD_DOUBLE = 1'b1
    } t_cmd;

    // orbitals leaving ket (and entering bra): one for a single, two for a double
    localparam logic [CNT_W-1:0] MOVE_CNT_SINGLE = CNT_W'(2 / 2);
    localparam logic [CNT_W-1:0] MOVE_CNT_DOUBLE = CNT_W'(4 / 2);

    localparam logic signed [1:0] PHASE_POS  = 2'sb01;
    localparam logic signed [1:0] PHASE_NEG  = 2'sb11;
    localparam logic signed [1:0] PHASE_NONE = 2'sb00;

    typedef struct packed {
        logic             ok;
        t_cmd             cmd;
        logic [IDX_W-1:0] from_lo;
        logic [IDX_W-1:0] from_hi;
        logic [IDX_W-1:0] to_lo;
        logic [IDX_W-1:0] to_hi;
    } t_locate;

    // binary search for the lowest set bit, six halving steps
    function automatic logic [IDX_W-1:0] lowest_idx(input logic [ORB_MAX-1:0] v);
        logic [ORB_MAX-1:0] w;
        logic [ORB_MAX-1:0] lm;
        logic [IDX_W-1:0]   idx;
        w   = v;
        idx = '0;
        for (int l = IDX_W - 1; l >= 0; l--) begin
            lm = (ORB_MAX'(1) << (1 << l)) - ORB_MAX'(1);
            if ((w & lm) == '0) begin
                idx[l] = 1'b1;
                w      = w >> (1 << l);
            end else begin
                w = w & lm;
            end
        end
        return idx;
    endfunction

    // binary search for the highest set bit
    function automatic logic [IDX_W-1:0] highest_idx(input logic [ORB_MAX-1:0] v);
        logic [ORB_MAX-1:0] w;
        logic [ORB_MAX-1:0] lm;
        logic [IDX_W-1:0]   idx;
        w   = v;
        idx = '0;
        for (int l = IDX_W - 1; l >= 0; l--) begin
            lm = (ORB_MAX'(1) << (1 << l)) - ORB_MAX'(1);
            if ((w >> (1 << l)) != '0) begin
                idx[l] = 1'b1;
                w      = w >> (1 << l);
            end else begin
                w = w & lm;
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/dep_locate.sv
// finds the moved orbitals, checks the difference count and builds the prefix parity of ket
`default_nettype none

module dep_locate #(
    parameter int NUM_ORBITALS = dep_pkg::DEF_NUM_ORBITALS
) (
    input  var dep_pkg::t_cmd            i_cmd,
    input  wire logic [NUM_ORBITALS-1:0] i_bra,
    input  wire logic [NUM_ORBITALS-1:0] i_ket,
    output dep_pkg::t_locate             o_loc,
    output logic [NUM_ORBITALS-1:0]      o_pre
);
    import dep_pkg::*;

    localparam int SCAN_LVL = $clog2(NUM_ORBITALS);

    logic [NUM_ORBITALS-1:0] delta;
    logic [NUM_ORBITALS-1:0] from_mask;
    logic [NUM_ORBITALS-1:0] to_mask;
    logic [CNT_W-1:0]        cnt_from;
    logic [CNT_W-1:0]        cnt_to;
    logic [CNT_W-1:0]        want;
    logic [NUM_ORBITALS-1:0] scan;

    assign delta     = i_bra ^ i_ket;
    assign from_mask = delta & i_ket;
    assign to_mask   = delta & i_bra;
    assign cnt_from  = CNT_W'($countones(from_mask));
    assign cnt_to    = CNT_W'($countones(to_mask));
    assign want      = (i_cmd == CMD_DOUBLE) ? MOVE_CNT_DOUBLE : MOVE_CNT_SINGLE;

    // with exactly two bits per mask the highest set bit is the second one; with one it equals the lowest
    always_comb begin
        o_loc.ok      = (cnt_from == want) && (cnt_to == want);
        o_loc.cmd     = i_cmd;
        o_loc.from_lo = lowest_idx(ORB_MAX'(from_mask));
        o_loc.from_hi = highest_idx(ORB_MAX'(from_mask));
        o_loc.to_lo   = lowest_idx(ORB_MAX'(to_mask));
        o_loc.to_hi   = highest_idx(ORB_MAX'(to_mask));
    end

    // inclusive xor scan, then shifted so bit k holds the parity of ket below k
    always_comb begin
        scan = i_ket;
        for (int d = 0; d < SCAN_LVL; d++) begin
            scan = scan ^ (scan << (1 << d));
        end
    end

    assign o_pre = {scan[NUM_ORBITALS-2:0], 1'b0};

endmodule

`default_nettype wire

// File: rtl/core/determinant_excitation_phase_unit.sv
// top level: fermionic sign of a single or double excitation between two determinants
// an accepted input word passes the input, mid and output regs on its way to the result word
// throughput: one word per cycle; each stage moves on when the next one is free
// the orbital search and prefix parity sit before the mid register, the sign after it
// reset clears the three stage valid flags only; data registers are not reset
`default_nettype none

module determinant_excitation_phase_unit #(
    parameter int NUM_ORBITALS = dep_pkg::DEF_NUM_ORBITALS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // bra_bits [63:0], ket_bits [127:64]
    input  wire logic [dep_pkg::S_TDATA_W-1:0] i_s_tdata,
    // command [0]
    input  wire logic                          i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // from_first [5:0], from_second [11:6], to_first [17:12], to_second [23:18],
    // phase [25:24], zero [31:26]
    output logic [dep_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // status [0]
    output logic                               o_m_tuser
);
    import dep_pkg::*;

    logic en_in;
    logic en_mid;
    logic en_out;

    logic                    r_in_valid;
    t_cmd                    r_in_cmd;
    logic [NUM_ORBITALS-1:0] r_in_bra;
    logic [NUM_ORBITALS-1:0] r_in_ket;

    t_locate                 loc;
    logic [NUM_ORBITALS-1:0] pre;

    logic                    r_mid_valid;
    t_locate                 r_mid_loc;
    logic [NUM_ORBITALS-1:0] r_mid_pre;

    logic                    r_out_valid;
    logic [M_TDATA_W-1:0]    r_out_data;
    logic                    r_out_status;
    logic [M_TDATA_W-1:0]    n_out_data;
    logic                    n_out_status;

    logic [ORB_MAX-1:0] pre_full;
    logic               p_i;
    logic               p_j;
    logic               p_a;
    logic               p_b;
    logic               odd;
    logic signed [1:0]  phase;

    assign en_out     = !r_out_valid || i_m_tready;
    assign en_mid     = !r_mid_valid || en_out;
    assign en_in      = !r_in_valid || en_mid;
    assign o_s_tready = en_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_in) begin
                r_in_valid <= i_s_tvalid;
            end
            if (en_mid) begin
                r_mid_valid <= r_in_valid;
            end
            if (en_out) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    // orbitals at or above the size are dropped here
    always_ff @(posedge i_clk) begin
        if (en_in && i_s_tvalid) begin
            r_in_cmd <= t_cmd'(i_s_tuser);
            r_in_bra <= i_s_tdata[NUM_ORBITALS-1:0];
            r_in_ket <= i_s_tdata[ORB_MAX +: NUM_ORBITALS];
        end
    end

    dep_locate #(
        .NUM_ORBITALS(NUM_ORBITALS)
    ) u_locate (
        .i_cmd (r_in_cmd),
        .i_bra (r_in_bra),
        .i_ket (r_in_ket),
        .o_loc (loc),
        .o_pre (pre)
    );

    always_ff @(posedge i_clk) begin
        if (en_mid && r_in_valid) begin
            r_mid_loc <= loc;
            r_mid_pre <= pre;
        end
    end

    // sign from the prefix parities of ket at each index, corrected for
    // orbitals already removed or added below it
    always_comb begin
        pre_full = ORB_MAX'(r_mid_pre);
        p_i      = pre_full[r_mid_loc.from_lo];
        p_j      = pre_full[r_mid_loc.from_hi];
        p_a      = pre_full[r_mid_loc.to_lo];
        p_b      = pre_full[r_mid_loc.to_hi];
        if (r_mid_loc.cmd == CMD_DOUBLE) begin
            odd = p_i ^ p_j ^ 1'b1 ^ p_a ^ p_b
                ^ (r_mid_loc.from_lo < r_mid_loc.to_hi)
                ^ (r_mid_loc.from_hi < r_mid_loc.to_hi)
                ^ (r_mid_loc.from_lo < r_mid_loc.to_lo)
                ^ (r_mid_loc.from_hi < r_mid_loc.to_lo);
        end else begin
            odd = p_i ^ p_a ^ (r_mid_loc.from_lo < r_mid_loc.to_lo);
        end
        phase = odd ? PHASE_NEG : PHASE_POS;

        if (!r_mid_loc.ok) begin
            n_out_data   = '0;
            n_out_status = 1'b1;
        end else if (r_mid_loc.cmd == CMD_DOUBLE) begin
            n_out_data   = {(M_TDATA_W - OUT_FIELD_W)'(0), phase,
                            r_mid_loc.to_hi, r_mid_loc.to_lo,
                            r_mid_loc.from_hi, r_mid_loc.from_lo};
            n_out_status = 1'b0;
        end else begin
            n_out_data   = {(M_TDATA_W - OUT_FIELD_W)'(0), phase,
                            IDX_W'(0), r_mid_loc.to_lo,
                            IDX_W'(0), r_mid_loc.from_lo};
            n_out_status = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_mid_valid) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

    // flagged words carry no orbitals and no sign
    a_flag_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("flagged word carries data");

    a_phase_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |->
            (o_m_tdata[25:24] == PHASE_POS || o_m_tdata[25:24] == PHASE_NEG))
        else $error("good word without a sign");

    a_from_ordered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser && o_m_tdata[11:6] != '0) |->
            (o_m_tdata[5:0] < o_m_tdata[11:6]))
        else $error("from orbitals out of order");

    a_to_ordered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser && o_m_tdata[23:18] != '0) |->
            (o_m_tdata[17:12] < o_m_tdata[23:18]))
        else $error("to orbitals out of order");

    a_from_to_differ : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[5:0] != o_m_tdata[17:12]))
        else $error("from and to orbital coincide");

endmodule

`default_nettype wire
